/* src/register_machine_execute_unit_defines.svh */
// Assertion macros for the execute unit
`ifndef REGISTER_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_MACHINE_EXECUTE_UNIT_DEFINES_SVH

`define RMEU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define RMEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rmeu_pkg.sv */
package rmeu_pkg;
	localparam int NumRegs    = 8;
	localparam int MemWords   = 1024;
	localparam int ProgWords  = 4096;
	localparam int StackDepth = 16;
	localparam int RegW   = $clog2(NumRegs);
	localparam int MemAw  = $clog2(MemWords);
	localparam int StackAw = $clog2(StackDepth);
	localparam int SpW    = $clog2(StackDepth + 1);

	localparam logic [4:0] K_ADD = 5'd0, K_SUB = 5'd1, K_AND = 5'd2, K_OR = 5'd3,
		K_XOR = 5'd4, K_NOT = 5'd5, K_SHR = 5'd6, K_SHL = 5'd7, K_MOVE = 5'd8,
		K_LOAD = 5'd9, K_STORE = 5'd10, K_JMP = 5'd11, K_JEQ = 5'd12,
		K_JGT = 5'd13, K_CALL = 5'd14, K_RET = 5'd15;

	localparam logic [2:0] ST_OK = 3'd0, ST_NEG_SHIFT = 3'd1, ST_BAD_ADDR = 3'd2,
		ST_OVERFLOW = 3'd3, ST_UNDERFLOW = 3'd4;

	typedef struct packed {
		logic [4:0]  kind;
		logic        use_imm;
		logic [2:0]  reg_a;
		logic [2:0]  reg_b;
		logic [31:0] immediate;
		logic [11:0] target;
	} instr_t;

	typedef struct packed {
		logic [11:0] next_pc;
		logic [2:0]  status;
		logic        write_valid;
		logic [2:0]  write_reg;
		logic [31:0] write_value;
	} result_t;
endpackage

/* src/rmeu_if.sv */
interface rmeu_instr_if;
	logic valid;
	logic ready;
	rmeu_pkg::instr_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rmeu_result_if;
	logic valid;
	logic ready;
	rmeu_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/register_machine_execute_unit.sv */
// Channel   Dir  Payload
// instr     in   kind, use_imm, reg_a, reg_b, immediate, target
// result    out  next_pc, status, write_valid, write_reg, write_value
// One instruction per cycle unless stalled; a load stalls for its registered read.
// After reset the data memory is cleared word by word; nothing executes then and
// the queue takes at most two transactions before input ready drops.
// A two-entry queue decouples input from execute; the output register holds on stall.
module register_machine_execute_unit (
	input  logic          clk,
	input  logic          arst_n,
	rmeu_instr_if.sink    instr,
	rmeu_result_if.source result
);
	logic             pop, head_valid;
	rmeu_pkg::instr_t head;

	rmeu_front u_front (
		.clk(clk), .arst_n(arst_n), .instr(instr), .pop(pop),
		.head_valid(head_valid), .head(head)
	);

	rmeu_back u_back (
		.clk(clk), .arst_n(arst_n), .head_valid(head_valid), .head(head),
		.pop(pop), .result(result)
	);
endmodule

/* src/rmeu_ram.sv */
module rmeu_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* src/rmeu_front.sv */
// Two-entry input instruction queue
module rmeu_front (
	input  logic                  clk,
	input  logic                  arst_n,
	rmeu_instr_if.sink            instr,
	input  logic                  pop,
	output logic                  head_valid,
	output rmeu_pkg::instr_t      head
);
	rmeu_pkg::instr_t q_q [2];
	logic [1:0] cnt_q;
	logic       push;

	assign instr.ready = (cnt_q != 2'd2);
	assign push = instr.valid && instr.ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head = q_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			q_q[0] <= q_q[1];
			if (push && cnt_q == 2'd1) q_q[0] <= instr.data;
			if (push && cnt_q == 2'd2) q_q[1] <= instr.data;
		end else if (push) begin
			if (cnt_q == 2'd0) q_q[0] <= instr.data;
			else q_q[1] <= instr.data;
		end
	end
endmodule

/* src/rmeu_back.sv */
// Execute: register file, data memory, pc and return stack.
// Memory clear sweeps all MemWords words after reset.
`include "register_machine_execute_unit_defines.svh"
module rmeu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  rmeu_pkg::instr_t head,
	output logic             pop,
	rmeu_result_if.source    result
);
	logic [31:0] rf_q [rmeu_pkg::NumRegs];
	logic [11:0] pc_q;
	logic [rmeu_pkg::SpW-1:0] sp_q;
	logic [11:0] rs_q [rmeu_pkg::StackDepth];
	logic [rmeu_pkg::MemAw:0] clr_q;
	logic clearing;

	// load holding stage
	logic             ld_s1;
	logic [2:0]       ld_reg_s1;
	logic [11:0]      ld_pc_s1;

	logic out_valid_q;
	rmeu_pkg::result_t out_q;

	logic [31:0] a, b, wval;
	logic [2:0]  st;
	logic        wv, taken, mem_ok, tgt_ok, do_store, space, ld_go;
	logic [11:0] seq, nxt;
	logic [rmeu_pkg::MemAw-1:0] ram_raddr, ram_waddr;
	logic [31:0] ram_rdata, ram_wdata;
	logic ram_we;
	rmeu_pkg::result_t res;

	assign clearing = !clr_q[rmeu_pkg::MemAw];
	// output register free after this edge, and no pending load result
	assign space = !ld_s1 && (!out_valid_q || result.ready);
	assign pop = head_valid && space && !clearing;

	assign a = rf_q[head.reg_a[rmeu_pkg::RegW-1:0]];
	assign b = head.use_imm ? head.immediate : rf_q[head.reg_b[rmeu_pkg::RegW-1:0]];
	assign seq = pc_q + 12'd1;
	assign mem_ok = (b < 32'(rmeu_pkg::MemWords));
	assign tgt_ok = (32'(head.target) < 32'(rmeu_pkg::ProgWords));
	assign ld_go = (head.kind == rmeu_pkg::K_LOAD) && (st == rmeu_pkg::ST_OK);

	always_comb begin
		st = rmeu_pkg::ST_OK;
		wv = 1'b0;
		wval = 32'd0;
		taken = 1'b0;
		nxt = seq;
		do_store = 1'b0;
		case (head.kind)
			rmeu_pkg::K_ADD: begin wv = 1'b1; wval = a + b; end
			rmeu_pkg::K_SUB: begin wv = 1'b1; wval = a - b; end
			rmeu_pkg::K_AND: begin wv = 1'b1; wval = a & b; end
			rmeu_pkg::K_OR:  begin wv = 1'b1; wval = a | b; end
			rmeu_pkg::K_XOR: begin wv = 1'b1; wval = a ^ b; end
			rmeu_pkg::K_NOT: begin wv = 1'b1; wval = ~a; end
			rmeu_pkg::K_SHR, rmeu_pkg::K_SHL: begin
				if (b[31]) begin
					st = rmeu_pkg::ST_NEG_SHIFT;
				end else begin
					wv = 1'b1;
					if (head.kind == rmeu_pkg::K_SHR)
						wval = (b > 32'd31) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
					else
						wval = (b > 32'd31) ? 32'd0 : (a << b[4:0]);
				end
			end
			rmeu_pkg::K_MOVE: begin wv = 1'b1; wval = b; end
			rmeu_pkg::K_LOAD: begin
				if (!mem_ok) st = rmeu_pkg::ST_BAD_ADDR;
			end
			rmeu_pkg::K_STORE: begin
				if (!mem_ok) st = rmeu_pkg::ST_BAD_ADDR;
				else do_store = 1'b1;
			end
			rmeu_pkg::K_JMP, rmeu_pkg::K_JEQ, rmeu_pkg::K_JGT: begin
				if (head.kind == rmeu_pkg::K_JMP) taken = 1'b1;
				else if (head.kind == rmeu_pkg::K_JEQ) taken = (a == b);
				else taken = ($signed(a) > $signed(b));
				if (taken) begin
					if (!tgt_ok) st = rmeu_pkg::ST_BAD_ADDR;
					else nxt = head.target;
				end
			end
			rmeu_pkg::K_CALL: begin
				if (!tgt_ok) st = rmeu_pkg::ST_BAD_ADDR;
				else if (sp_q >= rmeu_pkg::SpW'(rmeu_pkg::StackDepth))
					st = rmeu_pkg::ST_OVERFLOW;
				else nxt = head.target;
			end
			rmeu_pkg::K_RET: begin
				if (sp_q == '0) st = rmeu_pkg::ST_UNDERFLOW;
				else nxt = rs_q[rmeu_pkg::StackAw'(sp_q - 1'b1)];
			end
			default: ;
		endcase
		if (st != rmeu_pkg::ST_OK) begin
			nxt = pc_q;
			wv = 1'b0;
			wval = 32'd0;
		end
		res.next_pc = nxt;
		res.status = st;
		res.write_valid = wv;
		res.write_reg = wv ? head.reg_a : 3'd0;
		res.write_value = wval;
	end

	assign ram_raddr = b[rmeu_pkg::MemAw-1:0];
	assign ram_we = clearing || (pop && do_store);
	assign ram_waddr = clearing ? clr_q[rmeu_pkg::MemAw-1:0] : b[rmeu_pkg::MemAw-1:0];
	assign ram_wdata = clearing ? 32'd0 : a;

	rmeu_ram #(.Width(32), .Depth(rmeu_pkg::MemWords)) u_dmem (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			pc_q <= '0;
			sp_q <= '0;
			ld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < rmeu_pkg::NumRegs; i++) rf_q[i] <= '0;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			if (ld_s1 || (pop && !ld_go)) out_valid_q <= 1'b1;
			else if (result.valid && result.ready) out_valid_q <= 1'b0;
			if (ld_s1) begin
				ld_s1 <= 1'b0;
				rf_q[ld_reg_s1[rmeu_pkg::RegW-1:0]] <= ram_rdata;
			end
			if (pop) begin
				pc_q <= nxt;
				if (ld_go) begin
					ld_s1 <= 1'b1;
				end else begin
					if (wv) rf_q[head.reg_a[rmeu_pkg::RegW-1:0]] <= wval;
				end
				if (head.kind == rmeu_pkg::K_CALL && st == rmeu_pkg::ST_OK)
					sp_q <= sp_q + 1'b1;
				if (head.kind == rmeu_pkg::K_RET && st == rmeu_pkg::ST_OK)
					sp_q <= sp_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == rmeu_pkg::K_CALL && st == rmeu_pkg::ST_OK)
			rs_q[rmeu_pkg::StackAw'(sp_q)] <= seq;
		if (pop) begin
			ld_reg_s1 <= head.reg_a;
			ld_pc_s1 <= nxt;
			out_q <= res;
		end
		if (ld_s1) begin
			out_q.next_pc <= ld_pc_s1;
			out_q.status <= rmeu_pkg::ST_OK;
			out_q.write_valid <= 1'b1;
			out_q.write_reg <= ld_reg_s1;
			out_q.write_value <= ram_rdata;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data = out_q;

	`RMEU_ASSERT_IMPL(a_no_pop_clear, clk, arst_n, clearing, !pop, "pop during clear")
	`RMEU_ASSERT_NEXT(a_ld_done, clk, arst_n, ld_s1, out_valid_q && !ld_s1, "load lost")
	`RMEU_ASSERT_IMPL(a_sp_range, clk, arst_n, 1'b1,
		sp_q <= rmeu_pkg::SpW'(rmeu_pkg::StackDepth), "sp out of range")
endmodule

/* tb/sv/tb_register_machine_execute_unit.sv */
module tb_register_machine_execute_unit;
	localparam logic [4:0] K_NOP = 5'd16;
	localparam logic [4:0] K_UNUSED = 5'd31;

	logic clk;
	logic arst_n;
	rmeu_instr_if instr_ch ();
	rmeu_result_if result_ch ();

	register_machine_execute_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.instr(instr_ch.sink),
		.result(result_ch.source)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// machine state mirror
	logic [31:0] regs [rmeu_pkg::NumRegs];
	logic [31:0] dmem [rmeu_pkg::MemWords];
	logic [11:0] pc;
	logic [11:0] rstack [rmeu_pkg::StackDepth];
	int unsigned sp;

	rmeu_pkg::result_t expected_q[$];
	int errors;
	int sent;
	int checked;
	int send_idle_pct;
	int stall_pct;
	int status_seen [5];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %h expected %h (transaction %0d)", what, got, exp, checked);
		errors++;
	endtask

	function automatic logic [31:0] sra32(input logic [31:0] v, input logic [31:0] n);
		if (n > 31)
			return {32{v[31]}};
		return $unsigned($signed(v) >>> n[4:0]);
	endfunction

	function automatic rmeu_pkg::result_t execute(input rmeu_pkg::instr_t it);
		rmeu_pkg::result_t r;
		logic [11:0] seq;
		logic [31:0] a;
		logic [31:0] b;
		logic wv;
		logic [31:0] wval;
		logic [2:0] st;
		logic [11:0] nxt;
		logic taken;
		seq = pc + 12'd1;
		nxt = seq;
		st = rmeu_pkg::ST_OK;
		wv = 1'b0;
		wval = '0;
		taken = 1'b0;
		a = regs[it.reg_a];
		b = it.use_imm ? it.immediate : regs[it.reg_b];
		case (it.kind)
			rmeu_pkg::K_ADD: begin wv = 1'b1; wval = a + b; end
			rmeu_pkg::K_SUB: begin wv = 1'b1; wval = a - b; end
			rmeu_pkg::K_AND: begin wv = 1'b1; wval = a & b; end
			rmeu_pkg::K_OR: begin wv = 1'b1; wval = a | b; end
			rmeu_pkg::K_XOR: begin wv = 1'b1; wval = a ^ b; end
			rmeu_pkg::K_NOT: begin wv = 1'b1; wval = ~a; end
			rmeu_pkg::K_SHR, rmeu_pkg::K_SHL: begin
				if (b[31]) begin
					st = rmeu_pkg::ST_NEG_SHIFT;
				end else begin
					wv = 1'b1;
					if (it.kind == rmeu_pkg::K_SHR)
						wval = sra32(a, b);
					else
						wval = (b > 31) ? 32'd0 : a << b[4:0];
				end
			end
			rmeu_pkg::K_MOVE: begin wv = 1'b1; wval = b; end
			rmeu_pkg::K_LOAD: begin
				if (b >= rmeu_pkg::MemWords) begin
					st = rmeu_pkg::ST_BAD_ADDR;
				end else begin
					wv = 1'b1;
					wval = dmem[b];
				end
			end
			rmeu_pkg::K_STORE: begin
				if (b >= rmeu_pkg::MemWords)
					st = rmeu_pkg::ST_BAD_ADDR;
				else
					dmem[b] = a;
			end
			rmeu_pkg::K_JMP, rmeu_pkg::K_JEQ, rmeu_pkg::K_JGT: begin
				if (it.kind == rmeu_pkg::K_JMP)
					taken = 1'b1;
				else if (it.kind == rmeu_pkg::K_JEQ)
					taken = (a == b);
				else
					taken = ($signed(a) > $signed(b));
				if (taken)
					nxt = it.target;
			end
			rmeu_pkg::K_CALL: begin
				if (sp >= rmeu_pkg::StackDepth) begin
					st = rmeu_pkg::ST_OVERFLOW;
				end else begin
					rstack[sp] = seq;
					sp++;
					nxt = it.target;
				end
			end
			rmeu_pkg::K_RET: begin
				if (sp == 0) begin
					st = rmeu_pkg::ST_UNDERFLOW;
				end else begin
					sp--;
					nxt = rstack[sp];
				end
			end
			default: ;
		endcase
		if (st != rmeu_pkg::ST_OK) begin
			nxt = pc;
			wv = 1'b0;
			wval = '0;
		end
		if (wv)
			regs[it.reg_a] = wval;
		pc = nxt;
		r.next_pc = nxt;
		r.status = st;
		r.write_valid = wv;
		r.write_reg = wv ? it.reg_a : 3'd0;
		r.write_value = wval;
		status_seen[st]++;
		return r;
	endfunction

	task automatic send(input rmeu_pkg::instr_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			instr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.data <= it;
		@(posedge clk);
		while (!instr_ch.ready)
			@(posedge clk);
		expected_q.push_back(execute(it));
		sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n)
			result_ch.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		rmeu_pkg::result_t got;
		rmeu_pkg::result_t exp;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_q.size() == 0) begin
				report("unexpected result", 32'(got.next_pc), 32'd0);
			end else begin
				exp = expected_q.pop_front();
				if (got.next_pc !== exp.next_pc)
					report("next_pc", 32'(got.next_pc), 32'(exp.next_pc));
				if (got.status !== exp.status)
					report("status", 32'(got.status), 32'(exp.status));
				if (got.write_valid !== exp.write_valid)
					report("write_valid", 32'(got.write_valid), 32'(exp.write_valid));
				if (got.write_reg !== exp.write_reg)
					report("write_reg", 32'(got.write_reg), 32'(exp.write_reg));
				if (got.write_value !== exp.write_value)
					report("write_value", got.write_value, exp.write_value);
			end
			checked++;
		end
	end

	function automatic rmeu_pkg::instr_t make(input logic [4:0] k, input logic ui,
			input logic [2:0] ra, input logic [2:0] rb, input logic [31:0] imm,
			input logic [11:0] tg);
		rmeu_pkg::instr_t it;
		it.kind = k;
		it.use_imm = ui;
		it.reg_a = ra;
		it.reg_b = rb;
		it.immediate = imm;
		it.target = tg;
		return it;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(40);
			3: return -$urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	function automatic rmeu_pkg::instr_t rand_instr();
		rmeu_pkg::instr_t it;
		int sel;
		it.reg_a = 3'($urandom_range(7));
		it.reg_b = 3'($urandom_range(7));
		it.target = 12'($urandom_range(4095));
		it.immediate = rand_value();
		it.use_imm = 1'($urandom_range(1));
		sel = $urandom_range(99);
		if (sel < 3)
			it.kind = 5'(K_NOP + $urandom_range(15));
		else
			it.kind = 5'($urandom_range(15));
		// keep addresses mostly in range so memory sees traffic
		if ((it.kind == rmeu_pkg::K_LOAD || it.kind == rmeu_pkg::K_STORE) && it.use_imm
				&& $urandom_range(9) > 0)
			it.immediate = $urandom_range(rmeu_pkg::MemWords - 1);
		if ((it.kind == rmeu_pkg::K_SHR || it.kind == rmeu_pkg::K_SHL) && it.use_imm
				&& $urandom_range(3) > 0)
			it.immediate = $urandom_range(35);
		// keep the stack busy without pinning it full or empty
		if (it.kind == rmeu_pkg::K_CALL && sp >= rmeu_pkg::StackDepth && $urandom_range(3) > 0)
			it.kind = rmeu_pkg::K_RET;
		if (it.kind == rmeu_pkg::K_RET && sp == 0 && $urandom_range(3) > 0)
			it.kind = rmeu_pkg::K_CALL;
		return it;
	endfunction

	task automatic drain();
		int guard;
		guard = 0;
		instr_ch.valid <= 1'b0;
		while (expected_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic test_alu_edges();
		send(make(rmeu_pkg::K_MOVE, 1'b1, 3'd0, 3'd0, 32'h7fff_ffff, 12'd0));
		send(make(rmeu_pkg::K_MOVE, 1'b1, 3'd7, 3'd0, 32'h8000_0000, 12'd0));
		send(make(rmeu_pkg::K_ADD, 1'b1, 3'd0, 3'd0, 32'd1, 12'd0));
		send(make(rmeu_pkg::K_SUB, 1'b0, 3'd7, 3'd0, 32'd0, 12'd0));
		send(make(rmeu_pkg::K_AND, 1'b1, 3'd7, 3'd0, 32'hffff_ffff, 12'd0));
		send(make(rmeu_pkg::K_OR, 1'b0, 3'd1, 3'd7, 32'd0, 12'd0));
		send(make(rmeu_pkg::K_XOR, 1'b1, 3'd1, 3'd0, 32'h5555_aaaa, 12'd0));
		send(make(rmeu_pkg::K_NOT, 1'b0, 3'd2, 3'd0, 32'd0, 12'd0));
		send(make(rmeu_pkg::K_SHR, 1'b1, 3'd7, 3'd0, 32'd4, 12'd0));
		send(make(rmeu_pkg::K_SHR, 1'b1, 3'd7, 3'd0, 32'd40, 12'd0));
		send(make(rmeu_pkg::K_SHL, 1'b1, 3'd2, 3'd0, 32'd32, 12'd0));
		send(make(rmeu_pkg::K_SHL, 1'b1, 3'd2, 3'd0, 32'hffff_ffff, 12'd0));
		send(make(K_UNUSED, 1'b1, 3'd2, 3'd0, 32'd5, 12'd0));
		send(make(K_NOP, 1'b0, 3'd0, 3'd0, 32'd0, 12'd0));
	endtask

	task automatic test_memory_and_flow();
		send(make(rmeu_pkg::K_STORE, 1'b1, 3'd7, 3'd0, rmeu_pkg::MemWords - 1, 12'd0));
		send(make(rmeu_pkg::K_LOAD, 1'b1, 3'd3, 3'd0, rmeu_pkg::MemWords - 1, 12'd0));
		send(make(rmeu_pkg::K_LOAD, 1'b1, 3'd3, 3'd0, rmeu_pkg::MemWords, 12'd0));
		send(make(rmeu_pkg::K_STORE, 1'b1, 3'd3, 3'd0, 32'hffff_ffff, 12'd0));
		send(make(rmeu_pkg::K_JMP, 1'b0, 3'd0, 3'd0, 32'd0, 12'hfff));
		send(make(rmeu_pkg::K_JEQ, 1'b0, 3'd3, 3'd3, 32'd0, 12'd100));
		send(make(rmeu_pkg::K_JGT, 1'b1, 3'd0, 3'd0, 32'h8000_0000, 12'd200));
		send(make(rmeu_pkg::K_JGT, 1'b1, 3'd7, 3'd0, 32'h7fff_ffff, 12'd300));
		send(make(rmeu_pkg::K_RET, 1'b0, 3'd0, 3'd0, 32'd0, 12'd0));
		for (int i = 0; i <= rmeu_pkg::StackDepth; i++)
			send(make(rmeu_pkg::K_CALL, 1'b0, 3'd0, 3'd0, 32'd0, 12'(i * 250)));
		for (int i = 0; i <= rmeu_pkg::StackDepth; i++)
			send(make(rmeu_pkg::K_RET, 1'b0, 3'd0, 3'd0, 32'd0, 12'd0));
	endtask

	task automatic test_random(input int count, input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++)
			send(rand_instr());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		instr_ch.valid = 1'b0;
		instr_ch.data = '0;
		result_ch.ready = 1'b0;
		errors = 0;
		sent = 0;
		checked = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		pc = '0;
		sp = 0;
		foreach (regs[i]) regs[i] = '0;
		foreach (dmem[i]) dmem[i] = '0;
		foreach (rstack[i]) rstack[i] = '0;
		foreach (status_seen[i]) status_seen[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alu_edges();
		test_memory_and_flow();
		drain();
		test_random(400, 0, 0);
		test_random(350, 70, 0);
		test_random(350, 0, 70);
		test_random(400, 18, 18);
		$display("executed %0d instructions, %0d results checked", sent, checked);
		$display("status counts ok %0d negshift %0d badaddr %0d overflow %0d underflow %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (errors == 0 && expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
